FILE: rtl/rlee_pkg.sv
// Shared types and constants for the run-length encoder with escape tokens.
// No dependencies; used by the front end, the back end and the top level.
package rlee_pkg;

    // Configuration register indexes.
    localparam logic [1:0] REG_MIN_RUN    = 2'd0;
    localparam logic [1:0] REG_COUNT_BITS = 2'd1;
    localparam logic [1:0] REG_END_MARKER = 2'd2;

    // Reset values and limits of the configuration.
    localparam logic [3:0] MIN_RUN_RESET    = 4'd3;
    localparam logic [3:0] MIN_RUN_FLOOR    = 4'd2;
    localparam logic [4:0] COUNT_BITS_RESET = 5'd8;
    localparam logic [4:0] COUNT_BITS_FLOOR = 5'd1;

    // Byte value reserved for the end marker.
    localparam logic [7:0] ESC_BYTE = 8'hFF;

    // Token kinds.
    localparam logic KIND_LITERAL = 1'b0;
    localparam logic KIND_COUNT   = 1'b1;

    // Effective configuration, already clamped to its legal range.
    typedef struct packed {
        logic [3:0] min_run;
        logic [4:0] count_bits;
        logic       end_marker;
    } cfg_t;

    // Work for one input item, apart from the run length of run A.
    // Run A is a flushed run of any length, run B a single new literal,
    // and marker requests the end-of-stream marker.
    typedef struct packed {
        logic       a_valid;
        logic [7:0] a_byte;
        logic       b_valid;
        logic [7:0] b_byte;
        logic       marker;
    } cmd_t;

endpackage

FILE: rtl/rlee_fifo.sv
// Small register-based queue between the front end and the back end.
// Generic in width and depth; no package dependencies.
module rlee_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointers wrap at DEPTH so that any depth works, not only powers of two.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        count_next  = count_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

FILE: rtl/rlee_front.sv
// Front end: tracks the current run and turns each accepted byte into at most
// one queue request describing the tokens it causes. Depends on rlee_pkg.
module rlee_front #(
    parameter int RLW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlee_pkg::cfg_t       cfg,
    input  logic                 accept,
    input  logic [7:0]           in_byte,
    input  logic                 last_byte,
    output logic                 push,
    output rlee_pkg::cmd_t       cmd,
    output logic [RLW-1:0]       a_len
);

    logic [7:0]     held_reg, held_next;
    logic [RLW-1:0] len_reg, len_next;
    logic           act_reg, act_next;

    logic           same;
    logic [RLW-1:0] len_up;
    logic [RLW-1:0] cmax;
    logic [RLW-1:0] cap;
    logic           hit;

    always_comb
    begin
        same   = act_reg && (in_byte == held_reg);
        len_up = same ? len_reg + RLW'(1) : RLW'(1);
        cmax   = (RLW'(1) << cfg.count_bits) - RLW'(1);
        cap    = cmax + RLW'(cfg.min_run)
                 - RLW'(cfg.end_marker && (in_byte == rlee_pkg::ESC_BYTE));
        hit    = (len_up >= cap);

        cmd.a_byte = held_reg;
        cmd.b_byte = in_byte;
        cmd.marker = last_byte && cfg.end_marker;
        held_next  = in_byte;

        if (same)
        begin
            // The run grows; it ends here on reaching its cap or at the last byte.
            cmd.a_valid = hit || last_byte;
            cmd.b_valid = 1'b0;
            a_len       = len_up;
            act_next    = !(hit || last_byte);
            len_next    = (hit || last_byte) ? '0 : len_up;
        end
        else
        begin
            // A new run starts; the held one, if any, is flushed first.
            cmd.a_valid = act_reg;
            cmd.b_valid = last_byte;
            a_len       = len_reg;
            act_next    = !last_byte;
            len_next    = last_byte ? '0 : RLW'(1);
        end

        push = accept && (cmd.a_valid || cmd.b_valid || cmd.marker);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= '0;
            len_reg  <= '0;
            act_reg  <= 1'b0;
        end
        else if (accept)
        begin
            held_reg <= held_next;
            len_reg  <= len_next;
            act_reg  <= act_next;
        end
    end

endmodule

FILE: rtl/rlee_back.sv
// Back end: expands the request at the head of the queue into tokens, one
// per cycle unless the output stalls, into the output register. Depends on rlee_pkg.
module rlee_back #(
    parameter int RLW = 17
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rlee_pkg::cfg_t       cfg,
    input  logic                 q_empty,
    input  rlee_pkg::cmd_t       cmd,
    input  logic [RLW-1:0]       a_len,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 out_kind,
    output logic [15:0]          out_value,
    output logic                 out_last
);

    localparam logic [2:0] PH_START = 3'd0;
    localparam logic [2:0] PH_ALIT  = 3'd1;
    localparam logic [2:0] PH_ACNT  = 3'd2;
    localparam logic [2:0] PH_BLIT  = 3'd3;
    localparam logic [2:0] PH_MLIT  = 3'd4;
    localparam logic [2:0] PH_MCNT  = 3'd5;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  k_reg, k_next;
    logic        ov_reg, ov_next;
    logic        kind_reg, kind_next;
    logic [15:0] value_reg, value_next;
    logic        last_reg, last_next;

    logic           fire;
    logic [2:0]     cur;
    logic [2:0]     nxt;
    logic           has_acnt;
    logic [3:0]     lim;
    logic           ph_end;
    logic           done;
    logic [3:0]     k_inc;
    logic [RLW-1:0] cmax_len;
    logic [RLW-1:0] cnt;

    always_comb
    begin
        fire     = !q_empty && (!ov_reg || out_ready);
        has_acnt = cmd.a_valid && (a_len >= RLW'(cfg.min_run));
        lim      = (a_len < RLW'(cfg.min_run)) ? a_len[3:0] : cfg.min_run;
        k_inc    = k_reg + 4'd1;
        cmax_len = (RLW'(1) << cfg.count_bits) - RLW'(1);
        cnt      = (a_len - RLW'(cfg.min_run)) & cmax_len;

        if (phase_reg != PH_START)
            cur = phase_reg;
        else if (cmd.a_valid)
            cur = PH_ALIT;
        else if (cmd.b_valid)
            cur = PH_BLIT;
        else
            cur = PH_MLIT;

        kind_next  = rlee_pkg::KIND_LITERAL;
        value_next = 16'(cmd.a_byte);
        ph_end     = 1'b1;
        nxt        = PH_START;
        unique case (cur)
            PH_ALIT:
            begin
                ph_end = (k_inc == lim);
                if (has_acnt)
                    nxt = PH_ACNT;
                else if (cmd.b_valid)
                    nxt = PH_BLIT;
                else if (cmd.marker)
                    nxt = PH_MLIT;
            end
            PH_ACNT:
            begin
                kind_next  = rlee_pkg::KIND_COUNT;
                value_next = 16'(cnt);
                if (cmd.b_valid)
                    nxt = PH_BLIT;
                else if (cmd.marker)
                    nxt = PH_MLIT;
            end
            PH_BLIT:
            begin
                value_next = 16'(cmd.b_byte);
                if (cmd.marker)
                    nxt = PH_MLIT;
            end
            PH_MLIT:
            begin
                value_next = 16'(rlee_pkg::ESC_BYTE);
                ph_end     = (k_inc == cfg.min_run);
                nxt        = PH_MCNT;
            end
            PH_MCNT:
            begin
                kind_next  = rlee_pkg::KIND_COUNT;
                value_next = 16'((17'(1) << cfg.count_bits) - 17'(1));
            end
            default:
            begin
                nxt = PH_START;
            end
        endcase

        done      = ph_end && (nxt == PH_START);
        last_next = done;
        pop       = fire && done;

        phase_next = phase_reg;
        k_next     = k_reg;
        if (fire)
        begin
            if (ph_end)
            begin
                phase_next = nxt;
                k_next     = '0;
            end
            else
            begin
                phase_next = cur;
                k_next     = k_inc;
            end
        end

        ov_next = fire ? 1'b1 : (out_ready ? 1'b0 : ov_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_START;
            k_reg     <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            k_reg     <= k_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

endmodule

FILE: rtl/run_length_encoder_escape_top.sv
// Top level of the run-length encoder with escape count tokens.
// Holds the configuration registers; uses rlee_pkg, rlee_front, rlee_fifo, rlee_back.
//
//  channel   dir   signals                               request
//  s_*       in    s_tdata[7:0] byte, s_tlast last byte   s_tvalid && s_tready
//  m_*       out   m_tdata[15:0] value, m_tuser kind,     m_tvalid && m_tready
//                  m_tlast final token of its byte
//  cfg_*     in    cfg_addr index, cfg_wdata value        cfg_we
//
// A byte is taken every cycle while the request queue has room; the front end
// decides its tokens in the cycle it is taken.
// The back end sends one token per cycle from its output register while m_tready
// does not stall it: a flushed run of length n gives min(n, min_run_len) literal
// tokens, plus one count token once n reaches min_run_len; a last byte that starts
// a new run adds one literal, and the end marker is min_run_len literals and a count.
// Reset is asynchronous and active low; it clears the run state, the queue and
// the output valid flag, and loads the configuration defaults.
// A stalled output only fills the queue; input stalls once it is full.
module run_length_encoder_escape_top #(
    parameter int MAX_COUNT_BITS = 16,
    parameter int QUEUE_DEPTH    = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] token_value
    output logic        m_tuser,   // [0] token_kind
    output logic        m_tlast,   // final_token
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [4:0]  cfg_wdata
);

    // Wide enough for the longest run, 2^MAX_COUNT_BITS - 1 + 15.
    localparam int RLW = $clog2((1 << MAX_COUNT_BITS) + 15);
    localparam int QW  = $bits(rlee_pkg::cmd_t) + RLW;

    logic [3:0] min_run_reg;
    logic [4:0] count_bits_reg;
    logic       end_marker_reg;

    rlee_pkg::cfg_t cfg;

    logic                 accept;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_empty;
    rlee_pkg::cmd_t       f_cmd;
    logic [RLW-1:0]       f_len;
    rlee_pkg::cmd_t       h_cmd;
    logic [RLW-1:0]       h_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_run_reg    <= rlee_pkg::MIN_RUN_RESET;
            count_bits_reg <= rlee_pkg::COUNT_BITS_RESET;
            end_marker_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                rlee_pkg::REG_MIN_RUN:    min_run_reg    <= cfg_wdata[3:0];
                rlee_pkg::REG_COUNT_BITS: count_bits_reg <= cfg_wdata;
                rlee_pkg::REG_END_MARKER: end_marker_reg <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        cfg.min_run = (min_run_reg < rlee_pkg::MIN_RUN_FLOOR)
                      ? rlee_pkg::MIN_RUN_FLOOR : min_run_reg;
        if (count_bits_reg < rlee_pkg::COUNT_BITS_FLOOR)
            cfg.count_bits = rlee_pkg::COUNT_BITS_FLOOR;
        else if (count_bits_reg > 5'(MAX_COUNT_BITS))
            cfg.count_bits = 5'(MAX_COUNT_BITS);
        else
            cfg.count_bits = count_bits_reg;
        cfg.end_marker = end_marker_reg;
    end

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    rlee_front #(
        .RLW (RLW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .accept    (accept),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .push      (q_push),
        .cmd       (f_cmd),
        .a_len     (f_len)
    );

    rlee_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data ({f_cmd, f_len}),
        .pop     (q_pop),
        .rd_data ({h_cmd, h_len}),
        .full    (q_full),
        .empty   (q_empty)
    );

    rlee_back #(
        .RLW (RLW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_empty   (q_empty),
        .cmd       (h_cmd),
        .a_len     (h_len),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (m_tuser),
        .out_value (m_tdata),
        .out_last  (m_tlast)
    );

    // A last byte with the end marker on always queues work.
    a_marker_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s_tlast && end_marker_reg) |-> q_push)
        else $error("end marker request was not queued");

    // Finishing a request leaves its final token in the output register.
    a_pop_final: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (m_tvalid && m_tlast))
        else $error("finished request did not end in a final token");

    // A token only appears while a request was pending.
    a_token_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!q_empty))
        else $error("token produced without a queued request");

endmodule
